[src/itfc_pkg.sv]
// ----------------------------------------------------------------------------
// itfc_pkg: shared types and constants of the idle timeout frame checker
// Holds the buffer geometry, field widths, codes and the bundles that pass
// between the top level and the frame check unit.
// ----------------------------------------------------------------------------
package itfc_pkg;

   // frame buffer geometry
   localparam int BUFFER_DEPTH = 32;
   localparam int CNT_W        = $clog2(BUFFER_DEPTH);

   // field widths
   localparam int BYTE_W   = 8;
   localparam int LIMIT_W  = 8;
   localparam int EXPLEN_W = 5;
   localparam int IDLE_W   = 9;
   localparam int STATUS_W = 2;
   localparam int TEMP_W   = 15;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam int CMP_W    = (CNT_W > EXPLEN_W) ? CNT_W : EXPLEN_W;

   // register reset values
   localparam logic [LIMIT_W-1:0]  IDLE_LIMIT_RST = LIMIT_W'(100);
   localparam logic [EXPLEN_W-1:0] EXPLEN_RST     = EXPLEN_W'(9);

   // buffer positions of the temperature bytes
   localparam logic [CNT_W-1:0] TEMP_HI_IDX = CNT_W'(2);
   localparam logic [CNT_W-1:0] TEMP_LO_IDX = CNT_W'(3);

   // request operation codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_LIMIT      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_LENGTH = CSR_IDX_W'(1);

   // frame status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_LENGTH   = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_CHECKSUM = STATUS_W'(2);

   // buffer write from the byte path
   typedef struct packed {
      logic              we;
      logic [CNT_W-1:0]  addr;
      logic [BYTE_W-1:0] data;
   } buf_wr_type;

   // frame close request to the check unit
   typedef struct packed {
      logic                start;
      logic [CNT_W-1:0]    count;
      logic [EXPLEN_W-1:0] expected;
   } chk_req_type;

   // check unit status and result
   typedef struct packed {
      logic                busy;
      logic                done;
      logic [STATUS_W-1:0] status;
      logic [TEMP_W-1:0]   temp;
   } chk_rsp_type;

endpackage

[src/itfc_frame_check.sv]
// ----------------------------------------------------------------------------
// itfc_frame_check: frame buffer and iterative frame check unit
// Stores received bytes; a close request of good length walks the buffer one
// entry per cycle via an 8-bit adder; a good checksum forms the temperature.
// ----------------------------------------------------------------------------
module itfc_frame_check
   import itfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  buf_wr_type  buf_wr,
   input  chk_req_type chk_req,
   output chk_rsp_type chk_rsp
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_SUM     = 6'b000010,
      ST_SUM_END = 6'b000100,
      ST_T_HI    = 6'b001000,
      ST_T_LO    = 6'b010000,
      ST_DONE    = 6'b100000
   } chk_state_type;

   chk_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    last_ff, last_in;
   logic [BYTE_W-1:0]   sum_ff, sum_in;
   logic [TEMP_W-1:0]   prod_ff, prod_in;
   logic [TEMP_W-1:0]   temp_ff, temp_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [CNT_W-1:0]    rd_addr;
   logic [BYTE_W-1:0]   rd_data_ff;
   logic                len_ok;
   logic [TEMP_W-1:0]   rd_ext;

   logic [BYTE_W-1:0] mem [BUFFER_DEPTH];

   always_ff @(posedge clock) begin
      if (buf_wr.we) begin
         mem[buf_wr.addr] <= buf_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign len_ok = (chk_req.count != '0) &&
                   (CMP_W'(chk_req.count) == CMP_W'(chk_req.expected));
   assign rd_ext = TEMP_W'(rd_data_ff);

   always_comb begin
      case (state_ff)
         ST_SUM_END: rd_addr = TEMP_HI_IDX;
         ST_T_HI:    rd_addr = TEMP_LO_IDX;
         default:    rd_addr = idx_ff;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      last_in   = last_ff;
      sum_in    = sum_ff;
      prod_in   = prod_ff;
      temp_in   = temp_ff;
      status_in = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (chk_req.start) begin
               idx_in  = '0;
               sum_in  = '0;
               temp_in = '0;
               last_in = chk_req.count - CNT_W'(1);
               if (len_ok) begin
                  status_in = STATUS_OK;
                  state_in  = ST_SUM;
               end else begin
                  status_in = STATUS_LENGTH;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_SUM: begin
            // read data is registered, so it belongs to the previous cycle's address
            if (idx_ff != '0) begin
               sum_in = sum_ff + rd_data_ff;
            end
            idx_in = idx_ff + CNT_W'(1);
            if (idx_ff == last_ff) begin
               state_in = ST_SUM_END;
            end
         end
         ST_SUM_END: begin
            // rd_data now holds the checksum byte
            if (rd_data_ff != sum_ff) begin
               status_in = STATUS_CHECKSUM;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_T_HI;
            end
         end
         ST_T_HI: begin
            // x * 100 = x*64 + x*32 + x*4
            prod_in  = (rd_ext << 6) + (rd_ext << 5) + (rd_ext << 2);
            state_in = ST_T_LO;
         end
         ST_T_LO: begin
            temp_in  = prod_ff + rd_ext;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      last_ff   <= last_in;
      sum_ff    <= sum_in;
      prod_ff   <= prod_in;
      temp_ff   <= temp_in;
      status_ff <= status_in;
   end

   assign chk_rsp.busy   = (state_ff != ST_IDLE);
   assign chk_rsp.done   = (state_ff == ST_DONE);
   assign chk_rsp.status = status_ff;
   assign chk_rsp.temp   = temp_ff;

`ifndef SYNTHESIS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      chk_req.start |-> !chk_rsp.busy)
      else $error("close request while check unit busy");

   a_done_returns: assert property (@(posedge clock) disable iff (reset)
      chk_rsp.done |=> !chk_rsp.busy)
      else $error("check unit did not return to idle after done");

   a_temp_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (chk_rsp.done && chk_rsp.status != STATUS_OK) |-> (chk_rsp.temp == '0))
      else $error("temperature not zero on failed frame");
`endif

endmodule

[src/idle_timeout_frame_checker_unit.sv]
// ----------------------------------------------------------------------------
// idle_timeout_frame_checker_unit: idle timeout frame receiver and checker
// Collects received bytes, closes a frame after an idle period of ticks and
// reports length/checksum status with the decoded temperature.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): each request is a received byte (operation
//    byte) or one time tick. Byte requests are stored in a 32-entry ring
//    buffer and restart the idle counter.
//  - When a tick pushes the idle count past idle_limit, the frame closes:
//    count and idle state clear, and the check unit starts.
//  - Response channel (rsp_*): one response per closed frame, carrying the
//    status and byte2*100+byte3 (zero unless status is OK).
//  - Response: after a closing tick, the check unit goes straight to done on
//    a length error; otherwise it walks the buffer, one entry read per cycle,
//    and forms the temperature on a good checksum; rsp_valid follows done.
//  - Throughput: req_stall is high while the check unit runs, so one frame
//    is checked at a time; byte requests go at one per cycle unless stalled.
//  - A held response (rsp_valid with rsp_stall) stalls all requests, so a
//    close's result never finds the response register occupied.
//  - Reset: idle_limit = 100, expected_length = 9, frame inactive, no
//    response pending. Buffer contents are not cleared.
//  - Write csr_* only while the block is idle.
// ----------------------------------------------------------------------------
module idle_timeout_frame_checker_unit
   import itfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_frame_status,
   output logic [TEMP_W-1:0]     rsp_temperature_centi,
   // configuration
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [LIMIT_W-1:0]  idle_limit_ff, idle_limit_in;
   logic [EXPLEN_W-1:0] exp_len_ff, exp_len_in;
   logic [CNT_W-1:0]    byte_count_ff, byte_count_in;
   logic [IDLE_W-1:0]   idle_ff, idle_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [TEMP_W-1:0]   rsp_temp_ff, rsp_temp_in;

   logic              req_acc;
   logic              rsp_acc;
   logic [IDLE_W-1:0] idle_inc;
   logic              close;
   buf_wr_type        buf_wr;
   chk_req_type       chk_req;
   chk_rsp_type       chk_rsp;

   // a new close must find the response register empty or draining
   assign req_stall = chk_rsp.busy | (rsp_valid_ff & rsp_stall);
   assign req_acc   = req_valid & ~req_stall;
   assign rsp_acc   = rsp_valid_ff & ~rsp_stall;

   // idle counter: 0 = no frame, else 1 + ticks since last byte
   assign idle_inc = idle_ff + IDLE_W'(1);
   assign close    = req_acc && (req_operation == OP_TICK) && (idle_ff != '0) &&
                     (idle_inc > IDLE_W'(idle_limit_ff));

   always_comb begin
      idle_limit_in = idle_limit_ff;
      exp_len_in    = exp_len_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_IDLE_LIMIT:      idle_limit_in = csr_data[LIMIT_W-1:0];
            CSR_EXPECTED_LENGTH: exp_len_in    = csr_data[EXPLEN_W-1:0];
            default:             ;
         endcase
      end
   end

   always_comb begin
      byte_count_in = byte_count_ff;
      idle_in       = idle_ff;
      if (req_acc) begin
         if (req_operation == OP_BYTE) begin
            idle_in = IDLE_W'(1);
            // count wraps at the buffer depth; later bytes overwrite the start
            if (byte_count_ff == CNT_W'(BUFFER_DEPTH - 1)) begin
               byte_count_in = '0;
            end else begin
               byte_count_in = byte_count_ff + CNT_W'(1);
            end
         end else if (close) begin
            byte_count_in = '0;
            idle_in       = '0;
         end else if (idle_ff != '0) begin
            idle_in = idle_inc;
         end
      end
   end

   assign buf_wr.we   = req_acc && (req_operation == OP_BYTE);
   assign buf_wr.addr = byte_count_ff;
   assign buf_wr.data = req_rx_byte;

   assign chk_req.start    = close;
   assign chk_req.count    = byte_count_ff;
   assign chk_req.expected = exp_len_ff;

   itfc_frame_check u_check (
      .clock   (clock),
      .reset   (reset),
      .buf_wr  (buf_wr),
      .chk_req (chk_req),
      .chk_rsp (chk_rsp)
   );

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_temp_in   = rsp_temp_ff;
      if (chk_rsp.done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = chk_rsp.status;
         rsp_temp_in   = chk_rsp.temp;
      end else if (rsp_acc) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff <= IDLE_LIMIT_RST;
         exp_len_ff    <= EXPLEN_RST;
         byte_count_ff <= '0;
         idle_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idle_limit_ff <= idle_limit_in;
         exp_len_ff    <= exp_len_in;
         byte_count_ff <= byte_count_in;
         idle_ff       <= idle_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_temp_ff   <= rsp_temp_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_frame_status      = rsp_status_ff;
   assign rsp_temperature_centi = rsp_temp_ff;

`ifndef SYNTHESIS
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      chk_rsp.busy |-> req_stall)
      else $error("request accepted while frame check runs");

   a_done_slot_free: assert property (@(posedge clock) disable iff (reset)
      chk_rsp.done |-> !rsp_valid_ff)
      else $error("check result would overwrite a pending response");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      close |=> (byte_count_ff == '0) && (idle_ff == '0))
      else $error("frame state not cleared after close");
`endif

endmodule
